/* hdl/sidtoa_pkg.sv */
// sidtoa_pkg: shared types and constants for the signed integer to decimal text block.
// No dependencies.

package sidtoa_pkg;

	// ASCII output characters
	localparam int CHAR_W = 6;
	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

	// BCD conversion: binary bits consumed per converter cycle, bits per digit
	localparam int BITS_PER_STEP = 4;
	localparam int DIGIT_W       = 4;

	typedef enum logic [1:0] {
		CONV_IDLE,
		CONV_RUN,
		CONV_DONE
	} conv_state_t;

	// double-dabble correction of one BCD digit ahead of a shift
	function automatic logic [DIGIT_W-1:0] dabble_adj(input logic [DIGIT_W-1:0] d);
		return (d >= 4'd5) ? (d + 4'd3) : d;
	endfunction

endpackage

/* hdl/sidtoa_front.sv */
// sidtoa_front: input stage, splits each word into sign and magnitude.
// Depends on sidtoa_pkg only through the instantiating top level.

module sidtoa_front #(
	parameter int VALUE_WIDTH = 32,
	parameter int MAG_W       = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic                   push_valid,
	input  logic                   push_ready,
	output logic                   push_neg,
	output logic [MAG_W-1:0]       push_mag
);

	logic                   valid_s1;
	logic                   neg_s1;
	logic [MAG_W-1:0]       mag_s1;
	logic [VALUE_WIDTH-1:0] mag_w;

	// two's complement magnitude; most negative value yields 2^(W-1) unsigned
	assign mag_w = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_neg   = neg_s1;
	assign push_mag   = mag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			neg_s1 <= value[VALUE_WIDTH-1];
			mag_s1 <= MAG_W'(mag_w);
		end
	end

endmodule

/* hdl/sidtoa_queue.sv */
// sidtoa_queue: two-entry queue between the input stage and the converter.
// No package dependencies.

module sidtoa_queue #(
	parameter int WIDTH = 33
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* hdl/sidtoa_conv.sv */
// sidtoa_conv: iterative binary to BCD converter (shift-and-add-3).
// Depends on sidtoa_pkg (conv_state_t, dabble_adj, step constants).

module sidtoa_conv #(
	parameter int MAG_W = 32,
	parameter int NDIG  = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_neg,
	input  logic [MAG_W-1:0]     in_mag,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 out_neg,
	output logic [NDIG*4-1:0]    out_bcd
);

	import sidtoa_pkg::*;

	localparam int BCD_W  = NDIG * DIGIT_W;
	localparam int STEPS  = MAG_W / BITS_PER_STEP;
	localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

	conv_state_t       state_q;
	conv_state_t       state_d;
	logic [STEP_W-1:0] step_q;
	logic [MAG_W-1:0]  mag_q;
	logic [BCD_W-1:0]  bcd_q;
	logic              neg_q;
	logic [MAG_W-1:0]  mag_n;
	logic [BCD_W-1:0]  bcd_n;
	logic              load;
	logic              step_en;
	logic              last_step;

	assign last_step = (step_q == STEP_W'(STEPS - 1));
	assign out_neg   = neg_q;
	assign out_bcd   = bcd_q;

	// BITS_PER_STEP rounds of correct-then-shift per cycle
	always_comb begin
		bcd_n = bcd_q;
		mag_n = mag_q;
		for (int b = 0; b < BITS_PER_STEP; b++) begin
			for (int d = 0; d < NDIG; d++) begin
				bcd_n[d*DIGIT_W +: DIGIT_W] = dabble_adj(bcd_n[d*DIGIT_W +: DIGIT_W]);
			end
			bcd_n = {bcd_n[BCD_W-2:0], mag_n[MAG_W-1]};
			mag_n = {mag_n[MAG_W-2:0], 1'b0};
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		step_en   = 1'b0;
		unique case (state_q)
			CONV_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = CONV_RUN;
				end
			end
			CONV_RUN: begin
				step_en = 1'b1;
				if (last_step) begin
					state_d = CONV_DONE;
				end
			end
			CONV_DONE: begin
				out_valid = 1'b1;
				in_ready  = out_ready;
				if (out_ready) begin
					state_d = in_valid ? CONV_RUN : CONV_IDLE;
				end
			end
			default: begin
				state_d = CONV_IDLE;
			end
		endcase
	end

	assign load = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CONV_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				step_q <= '0;
			end else if (step_en) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mag_q <= in_mag;
			bcd_q <= '0;
			neg_q <= in_neg;
		end else if (step_en) begin
			mag_q <= mag_n;
			bcd_q <= bcd_n;
		end
	end

endmodule

/* hdl/sidtoa_emit.sv */
// sidtoa_emit: walks a BCD word from the top digit down and drives the character output.
// Depends on sidtoa_pkg (ASCII constants, digit width).

module sidtoa_emit #(
	parameter int NDIG = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        in_neg,
	input  logic [NDIG*4-1:0]           in_bcd,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [sidtoa_pkg::CHAR_W-1:0] text_char,
	output logic                        last_char
);

	import sidtoa_pkg::*;

	localparam int BCD_W = NDIG * DIGIT_W;
	localparam int IDX_W = $clog2(NDIG);

	logic               busy_q;
	logic               sign_q;
	logic               out_valid_q;
	logic [IDX_W-1:0]   idx_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;
	logic [IDX_W-1:0]   top_idx;
	logic [DIGIT_W-1:0] digit;
	logic               load_ok;
	logic               emit;
	logic               finishing;
	logic               take;

	// highest nonzero digit; zero value leaves index 0 so a single '0' goes out
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (in_bcd[i*DIGIT_W +: DIGIT_W] != '0) begin
				top_idx = IDX_W'(i);
			end
		end
	end

	assign digit     = bcd_q[idx_q*DIGIT_W +: DIGIT_W];
	assign load_ok   = !out_valid_q || out_ready;
	assign emit      = busy_q && load_ok;
	assign finishing = emit && !sign_q && (idx_q == '0);
	assign in_ready  = !busy_q || finishing;
	assign take      = in_valid && in_ready;

	assign out_valid = out_valid_q;
	assign text_char = char_q;
	assign last_char = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			sign_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_ok) begin
				out_valid_q <= busy_q;
			end
			// a new word taken on the last character keeps the emitter busy
			if (take) begin
				busy_q <= 1'b1;
				sign_q <= in_neg;
			end else if (emit) begin
				if (sign_q) begin
					sign_q <= 1'b0;
				end else if (idx_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= sign_q ? ASCII_MINUS : (ASCII_ZERO + CHAR_W'(digit));
			last_q <= !sign_q && (idx_q == '0);
			if (!sign_q && (idx_q != '0)) begin
				idx_q <= idx_q - 1'b1;
			end
		end
		if (take) begin
			idx_q <= top_idx;
			bcd_q <= in_bcd;
		end
	end

endmodule

/* hdl/signed_int_to_decimal_ascii.sv */
// signed_int_to_decimal_ascii: top level, signed integer to decimal ASCII text.
// Depends on sidtoa_pkg, sidtoa_front, sidtoa_queue, sidtoa_conv, sidtoa_emit.
//
// Usage:
//   Input channel (in_valid/in_ready/value): one signed two's complement word
//   per accepted handshake. Output channel (out_valid/out_ready/text_char/
//   last_char): one ASCII character per handshake; '-' first for negative values,
//   then the digits most significant first, no leading zeros. last_char marks
//   the final character of each value's text.
//   Path: a value's word passes the input register, the queue, the converter
//   and the emitter, and its characters leave through the output register.
//   A value's text is 1 to 11 characters at 32 bits. The shift-and-add-3 BCD
//   converter handles 4 magnitude bits per cycle; the output port sends one
//   character per cycle while out_ready is high. Conversion of the next
//   value overlaps emission of the current one.
//   Reset (arst_n low, asynchronous) empties every stage; nothing else is held.
//   When out_ready is low the output register holds, the emitter waits, and
//   back-pressure fills the converter, the 2-entry queue and the input
//   register before in_ready drops.

module signed_int_to_decimal_ascii #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sidtoa_pkg::CHAR_W-1:0] text_char,
	output logic                          last_char
);

	import sidtoa_pkg::*;

	// magnitude padded up to whole converter steps
	localparam int MAG_W = ((VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP) * BITS_PER_STEP;
	// enough decimal digits for 2^(VALUE_WIDTH-1)
	localparam int NDIG  = (VALUE_WIDTH * 3) / 10 + 1;
	localparam int BCD_W = NDIG * DIGIT_W;

	// front -> queue
	logic             fq_valid;
	logic             fq_ready;
	logic             fq_neg;
	logic [MAG_W-1:0] fq_mag;

	// queue -> converter
	logic             qc_valid;
	logic             qc_ready;
	logic [MAG_W:0]   qc_data;

	// converter -> emitter
	logic             ce_valid;
	logic             ce_ready;
	logic             ce_neg;
	logic [BCD_W-1:0] ce_bcd;

	sidtoa_front #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.MAG_W      (MAG_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.push_valid(fq_valid),
		.push_ready(fq_ready),
		.push_neg  (fq_neg),
		.push_mag  (fq_mag)
	);

	// word layout in queue: sign on top, magnitude below
	sidtoa_queue #(
		.WIDTH(MAG_W + 1)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(fq_valid),
		.push_ready(fq_ready),
		.push_data ({fq_neg, fq_mag}),
		.pop_valid (qc_valid),
		.pop_ready (qc_ready),
		.pop_data  (qc_data)
	);

	sidtoa_conv #(
		.MAG_W(MAG_W),
		.NDIG (NDIG)
	) u_conv (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (qc_valid),
		.in_ready (qc_ready),
		.in_neg   (qc_data[MAG_W]),
		.in_mag   (qc_data[MAG_W-1:0]),
		.out_valid(ce_valid),
		.out_ready(ce_ready),
		.out_neg  (ce_neg),
		.out_bcd  (ce_bcd)
	);

	sidtoa_emit #(
		.NDIG(NDIG)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (ce_valid),
		.in_ready (ce_ready),
		.in_neg   (ce_neg),
		.in_bcd   (ce_bcd),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.text_char(text_char),
		.last_char(last_char)
	);

endmodule

/* tb/sv/signed_int_to_decimal_ascii_test.sv */
`timescale 1ns / 1ps
// signed_int_to_decimal_ascii_test: self-checking bench for the signed integer to decimal text block.
// Depends on sidtoa_pkg and signed_int_to_decimal_ascii; directed table, then random words,
// with random idle bursts on both channels.

module signed_int_to_decimal_ascii_test;

	import sidtoa_pkg::*;

	localparam int VALUE_W = 32;
	localparam int TEXT_W = 88;		// room for 11 typed characters, right-justified
	localparam int RANDOM_WORDS = 380;
	localparam int QUIET_FROM = 300;	// no idling on either side from this random word on
	localparam int DRAIN_CYCLES = 40;	// settle time after the last expected character is seen
	localparam logic [TEXT_W-1:0] NO_TEXT = '0;

	// one expected character of a value's text
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              is_last;
	} text_char_t;

	// directed row: the word, and its text where it is plain to read off (else NO_TEXT)
	typedef struct packed {
		logic [VALUE_W-1:0] word;
		logic [TEXT_W-1:0]  text;
	} directed_row_t;

	localparam int DIRECTED_ROWS = 22;

	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{32'sd0,           "0"},
		'{32'sd1,           "1"},
		'{-32'sd1,          "-1"},
		'{32'sd9,           "9"},
		'{32'sd10,          "10"},
		'{-32'sd10,         "-10"},
		'{32'h7FFF_FFFF,    "2147483647"},
		'{32'h8000_0000,    "-2147483648"},
		'{32'h8000_0001,    "-2147483647"},
		'{32'hFFFF_FFFF,    "-1"},
		'{32'sd99,          NO_TEXT},
		'{32'sd100,         NO_TEXT},
		'{-32'sd99999,      NO_TEXT},
		'{32'sd999999999,   NO_TEXT},
		'{32'sd1000000000,  NO_TEXT},
		'{-32'sd1000000000, NO_TEXT},
		'{32'h5555_5555,    NO_TEXT},
		'{32'hAAAA_AAAA,    NO_TEXT},
		'{32'sd1234567890,  NO_TEXT},
		'{-32'sd987654321,  NO_TEXT},
		'{32'h0001_0000,    NO_TEXT},
		'{-32'sd5,          NO_TEXT}
	};

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [VALUE_W-1:0] value;
	logic out_valid;
	logic out_ready;
	logic [CHAR_W-1:0] text_char;
	logic last_char;

	// typed text that travels with the word on the input channel (NO_TEXT: use the predictor)
	logic [TEXT_W-1:0] typed_text;

	text_char_t pending_text [$];	// characters still owed, oldest first
	text_char_t head_char;
	int mismatch_count;
	logic source_gaps;		// input side may insert idle bursts
	logic sink_stalls;		// output side may drop ready in bursts

	signed_int_to_decimal_ascii #(
		.VALUE_WIDTH(VALUE_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.value    (value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.text_char(text_char),
		.last_char(last_char)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Decimal text of one word: sign first when negative, then the digits most
	// significant first. The magnitude is taken at full width as unsigned, so the
	// most negative value comes out as 2^31 without overflow.
	function automatic void queue_decimal_text(input logic [VALUE_W-1:0] word);
		logic neg;
		logic [VALUE_W-1:0] mag;
		logic [3:0] digits [0:23];
		int n;
		int k;
		text_char_t c;
		neg = word[VALUE_W-1];
		mag = neg ? (~word + 1'b1) : word;
		n = 0;
		do begin
			digits[n] = 4'(mag % 10);
			mag = mag / 10;
			n++;
		end while (mag != 0);
		if (neg) begin
			c.ch = ASCII_MINUS;
			c.is_last = 1'b0;
			pending_text.push_back(c);
		end
		for (k = n - 1; k >= 0; k--) begin
			c.ch = ASCII_ZERO + CHAR_W'(digits[k]);
			c.is_last = (k == 0);
			pending_text.push_back(c);
		end
	endfunction

	// typed text is right-justified, so the lowest byte is the last character
	function automatic void queue_typed_text(input logic [TEXT_W-1:0] txt);
		logic [7:0] b;
		text_char_t c;
		for (int i = TEXT_W / 8 - 1; i >= 0; i--) begin
			b = txt[i*8 +: 8];
			if (b != 8'd0) begin
				c.ch = b[CHAR_W-1:0];
				c.is_last = (i == 0);
				pending_text.push_back(c);
			end
		end
	endfunction

	task automatic note_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("MISMATCH at %0t ns: %s", $time, what);
	endtask

	// Both channels are watched at the rising edge. A word's first character comes
	// many cycles after the word, so the order of the two checks does not matter.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				if (typed_text != NO_TEXT)
					queue_typed_text(typed_text);
				else
					queue_decimal_text(value);
			end
			if (out_valid && out_ready) begin
				if (pending_text.size() == 0) begin
					note_mismatch($sformatf("unexpected char %0d last %0d",
						text_char, last_char));
				end else begin
					head_char = pending_text.pop_front();
					if (text_char !== head_char.ch || last_char !== head_char.is_last)
						note_mismatch($sformatf("char exp %0d last %0d, got %0d last %0d",
							head_char.ch, head_char.is_last, text_char, last_char));
				end
			end
		end
	end

	// Present one word at the falling edge and hold it until accepted. An idle
	// burst, when taken, lowers valid first; otherwise valid stays high from the
	// previous word, so it is assigned once per step.
	task automatic send_word(input logic [VALUE_W-1:0] word, input logic [TEXT_W-1:0] txt);
		if (source_gaps && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_valid <= 1'b1;
		value <= word;
		typed_text <= txt;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Random word mix: a quarter raw 32-bit patterns (every bit both ways), 45 of
	// 100 with an even spread of digit counts and sign, plus values near powers of
	// ten, small values around zero, and the two extremes.
	function automatic logic [VALUE_W-1:0] random_word();
		int pick;
		int ndig;
		int near_zero;
		longint lo;
		longint hi;
		longint mag;
		pick = $urandom_range(0, 99);
		if (pick < 25)
			return $urandom;
		if (pick < 35) begin
			near_zero = $urandom_range(0, 40);
			near_zero -= 20;
			return near_zero;
		end
		if (pick < 38)
			return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
		ndig = $urandom_range(1, 10);
		lo = 1;
		repeat (ndig - 1) lo *= 10;
		if (pick < 55) begin
			// one below, at or one above a power of ten
			mag = lo + $urandom_range(0, 2) - 1;
		end else begin
			hi = lo * 10 - 1;
			if (ndig == 1)
				lo = 0;
			if (hi > 64'sd2147483647)
				hi = 64'sd2147483647;
			mag = lo + longint'($urandom) % (hi - lo + 1);
		end
		if ($urandom_range(0, 1))
			mag = -mag;
		return mag[VALUE_W-1:0];
	endfunction

	// Output side: ready drops in random bursts while stalls are enabled.
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (sink_stalls && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	initial begin
		in_valid = 1'b0;
		value = '0;
		typed_text = NO_TEXT;
		out_ready = 1'b0;
		source_gaps = 1'b0;
		sink_stalls = 1'b0;
		mismatch_count = 0;
		arst_n = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		source_gaps = 1'b1;
		sink_stalls = 1'b1;
		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_word(directed_rows[i].word, directed_rows[i].text);

		// random words in windows of 40; each window picks its own idling, and the
		// tail runs with none so back-to-back words overlap conversion and output
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i >= QUIET_FROM) begin
				source_gaps = 1'b0;
				sink_stalls = 1'b0;
			end else if (i % 40 == 0) begin
				source_gaps = ($urandom_range(0, 3) != 0);
				sink_stalls = ($urandom_range(0, 3) != 0);
			end
			send_word(random_word(), NO_TEXT);
		end
		in_valid <= 1'b0;

		while (pending_text.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// run limit: far above the slowest legal run (about 130 us)
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

/* sim.f */
hdl/sidtoa_pkg.sv
hdl/sidtoa_front.sv
hdl/sidtoa_queue.sv
hdl/sidtoa_conv.sv
hdl/sidtoa_emit.sv
hdl/signed_int_to_decimal_ascii.sv
tb/sv/signed_int_to_decimal_ascii_test.sv
